FILE: rtl/assert_macros.svh
// assertion macros shared by the stack machine rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/sme_pkg.sv
// types, opcodes and command/status structs for the stack machine executor
// no dependencies; imported by every module of the block except sme_ram
package sme_pkg;

    localparam int DATA_W          = 32;
    localparam int IMM_W           = 24;
    localparam int DEF_STACK_DEPTH = 128;

    localparam logic [7:0] OP_HALT  = 8'd0;
    localparam logic [7:0] OP_PUSH  = 8'd1;
    localparam logic [7:0] OP_ADD   = 8'd2;
    localparam logic [7:0] OP_SUB   = 8'd3;
    localparam logic [7:0] OP_MUL   = 8'd4;
    localparam logic [7:0] OP_DIV   = 8'd5;
    localparam logic [7:0] OP_MOD   = 8'd6;
    localparam logic [7:0] OP_RDINT = 8'd7;
    localparam logic [7:0] OP_WRINT = 8'd8;
    localparam logic [7:0] OP_RDCHR = 8'd9;
    localparam logic [7:0] OP_WRCHR = 8'd10;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_HALTED    = 3'd1,
        ST_DIV_ZERO  = 3'd2,
        ST_BAD_OP    = 3'd3,
        ST_UNDERFLOW = 3'd4,
        ST_OVERFLOW  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        CL_HALT,
        CL_PUSH,
        CL_ARITH,
        CL_WRITE,
        CL_BAD
    } t_op_class;

    typedef struct packed {
        logic [7:0]               op;
        logic signed [IMM_W-1:0]  immediate;
        logic signed [DATA_W-1:0] input_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]               status;
        logic                     out_valid;
        logic                     out_is_char;
        logic signed [DATA_W-1:0] out_value;
        logic [7:0]               stack_depth;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    rd_second;
        logic    cap_b;
        logic    push;
        logic    pop;
        logic    alu_go;
        logic    div_go;
        logic    wb_alu;
        logic    wb_div;
        logic    finish;
        t_status fin_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op_class cls;
        logic      is_div;
        logic      halted;
        logic      sp_full;
        logic      sp_lt2;
        logic      sp_zero;
        logic      b_zero;
        logic      div_done;
        logic      out_free;
    } t_sts;

    function automatic t_op_class op_class(input logic [7:0] op);
        t_op_class cls;
        unique case (op)
            OP_HALT:                          cls = CL_HALT;
            OP_PUSH, OP_RDINT, OP_RDCHR:      cls = CL_PUSH;
            OP_ADD, OP_SUB, OP_MUL,
            OP_DIV, OP_MOD:                   cls = CL_ARITH;
            OP_WRINT, OP_WRCHR:               cls = CL_WRITE;
            default:                          cls = CL_BAD;
        endcase
        return cls;
    endfunction

endpackage

FILE: rtl/sme_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/sme_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
// depends on sme_pkg and assert_macros.svh
`include "assert_macros.svh"

module sme_div
    import sme_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_mod,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output logic              o_done,
    output logic [DATA_W-1:0] o_result
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_dvs;
    logic              r_neg_q;
    logic              r_neg_r;
    logic              r_mod;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic              last;

    assign mag_a  = i_a[DATA_W-1] ? (~i_a + 1'b1) : i_a;
    assign mag_b  = i_b[DATA_W-1] ? (~i_b + 1'b1) : i_b;
    assign rem_sh = {r_rem, r_q[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};
    assign last   = (r_cnt == CNT_W'(DATA_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q     <= mag_a;
            r_dvs   <= mag_b;
            r_rem   <= '0;
            r_neg_q <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
            r_neg_r <= i_a[DATA_W-1];
            r_mod   <= i_mod;
        end else if (r_busy) begin
            // restoring step: remainder never exceeds the divisor magnitude
            r_rem <= diff[DATA_W] ? rem_sh[DATA_W-1:0] : diff[DATA_W-1:0];
            r_q   <= {r_q[DATA_W-2:0], ~diff[DATA_W]};
        end
    end

    always_comb begin
        if (r_mod) begin
            o_result = r_neg_r ? (~r_rem + 1'b1) : r_rem;
        end else begin
            o_result = r_neg_q ? (~r_q + 1'b1) : r_q;
        end
    end

    assign o_done = r_done;

    `ASSERT_CLK(a_div_start_idle, i_clk, i_rst_n, i_start |-> !r_busy, "divider restarted while busy")

endmodule

FILE: rtl/sme_datapath.sv
// stack machine datapath: item latch, stack pointer, operand ram, alu, divider,
// output register; depends on sme_pkg, sme_ram, sme_div and assert_macros.svh
`include "assert_macros.svh"

module sme_datapath
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_cmd      i_cmd,
    input  logic      i_out_stall,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_item o_out
);

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    logic [7:0]        r_op;
    logic [IMM_W-1:0]  r_imm;
    logic [DATA_W-1:0] r_ival;
    logic [SP_W-1:0]   r_sp;
    logic [SP_W-1:0]   n_sp;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_alu;
    logic              r_halted;
    logic              r_emit;
    logic              r_emit_char;
    logic [DATA_W-1:0] r_emit_val;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [SP_W-1:0]   sp_m1;
    logic [SP_W-1:0]   sp_m2;
    logic [SP_W+7:0]   sp_ext;
    logic [DATA_W-1:0] rd_data;
    logic [DATA_W-1:0] push_val;
    logic [DATA_W-1:0] product;
    logic [DATA_W-1:0] div_res;
    logic              div_done;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;

    function automatic logic [DATA_W-1:0] sext8(input logic [DATA_W-1:0] v);
        return {{(DATA_W - 8){v[7]}}, v[7:0]};
    endfunction

    assign sp_m1  = r_sp - 1'b1;
    assign sp_m2  = r_sp - SP_W'(2);
    assign sp_ext = {8'd0, r_sp};

    always_comb begin
        if (r_op == OP_PUSH) begin
            push_val = {{(DATA_W - IMM_W){r_imm[IMM_W-1]}}, r_imm};
        end else if (r_op == OP_RDINT) begin
            push_val = r_ival;
        end else begin
            push_val = sext8(r_ival);
        end
    end

    assign product = rd_data * r_b;
    assign rd_addr = i_cmd.rd_second ? sp_m2[AW-1:0] : sp_m1[AW-1:0];

    always_comb begin
        wr_en   = i_cmd.push || i_cmd.wb_alu || i_cmd.wb_div;
        wr_addr = i_cmd.push ? r_sp[AW-1:0] : sp_m2[AW-1:0];
        if (i_cmd.push) begin
            wr_data = push_val;
        end else if (i_cmd.wb_div) begin
            wr_data = div_res;
        end else begin
            wr_data = r_alu;
        end
    end

    always_comb begin
        n_sp = r_sp;
        if (i_cmd.push) begin
            n_sp = r_sp + 1'b1;
        end else if (i_cmd.pop || i_cmd.wb_alu || i_cmd.wb_div) begin
            n_sp = sp_m1;
        end
    end

    sme_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sme_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_go),
        .i_mod    (r_op == OP_MOD),
        .i_a      (rd_data),
        .i_b      (r_b),
        .o_done   (div_done),
        .o_result (div_res)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_halted    <= 1'b0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sp <= n_sp;
            if (i_cmd.load) begin
                r_emit <= 1'b0;
            end else if (i_cmd.pop) begin
                r_emit <= 1'b1;
            end
            if (i_cmd.finish && (i_cmd.fin_status != ST_OK)) begin
                r_halted <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_in.op;
            r_imm       <= i_in.immediate;
            r_ival      <= i_in.input_value;
            r_emit_char <= 1'b0;
            r_emit_val  <= '0;
        end else if (i_cmd.pop) begin
            r_emit_char <= (r_op == OP_WRCHR);
            r_emit_val  <= (r_op == OP_WRCHR) ? sext8(rd_data) : rd_data;
        end
        if (i_cmd.cap_b) begin
            r_b <= rd_data;
        end
        if (i_cmd.alu_go) begin
            if (r_op == OP_ADD) begin
                r_alu <= rd_data + r_b;
            end else if (r_op == OP_SUB) begin
                r_alu <= rd_data - r_b;
            end else begin
                r_alu <= product;
            end
        end
        if (i_cmd.finish) begin
            r_out.status      <= i_cmd.fin_status;
            r_out.out_valid   <= r_emit;
            r_out.out_is_char <= r_emit_char;
            r_out.out_value   <= r_emit_val;
            r_out.stack_depth <= sp_ext[7:0];
        end
    end

    always_comb begin
        o_sts.cls      = op_class(r_op);
        o_sts.is_div   = (r_op == OP_DIV) || (r_op == OP_MOD);
        o_sts.halted   = r_halted;
        o_sts.sp_full  = (r_sp >= SP_W'(STACK_DEPTH));
        o_sts.sp_lt2   = (r_sp < SP_W'(2));
        o_sts.sp_zero  = (r_sp == '0);
        o_sts.b_zero   = (r_b == '0);
        o_sts.div_done = div_done;
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ASSERT_NEVER(a_sp_range, i_clk, i_rst_n, r_sp > SP_W'(STACK_DEPTH), "stack pointer past depth")
    `ASSERT_CLK(a_halt_sticky, i_clk, i_rst_n, r_halted |=> r_halted, "halted flag dropped")

endmodule

FILE: rtl/sme_ctrl.sv
// stack machine controller: sequences decode, stack reads, execute and result
// depends on sme_pkg
module sme_ctrl
    import sme_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_B,
        S_RD_A,
        S_EXEC,
        S_DIV,
        S_FIN
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_fin_status;
    t_status n_fin_status;

    always_comb begin
        n_state      = r_state;
        n_fin_status = r_fin_status;
        o_cmd        = '0;
        o_cmd.fin_status = r_fin_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FIN;
                if (i_sts.halted) begin
                    n_fin_status = ST_HALTED;
                end else begin
                    unique case (i_sts.cls)
                        CL_HALT: begin
                            n_fin_status = ST_HALTED;
                        end
                        CL_PUSH: begin
                            if (i_sts.sp_full) begin
                                n_fin_status = ST_OVERFLOW;
                            end else begin
                                o_cmd.push   = 1'b1;
                                n_fin_status = ST_OK;
                            end
                        end
                        CL_ARITH: begin
                            if (i_sts.sp_lt2) begin
                                n_fin_status = ST_UNDERFLOW;
                            end else begin
                                n_state = S_RD_B;
                            end
                        end
                        CL_WRITE: begin
                            if (i_sts.sp_zero) begin
                                n_fin_status = ST_UNDERFLOW;
                            end else begin
                                n_state = S_RD_B;
                            end
                        end
                        default: begin
                            n_fin_status = ST_BAD_OP;
                        end
                    endcase
                end
            end
            S_RD_B: begin
                o_cmd.cap_b = 1'b1;
                if (i_sts.cls == CL_WRITE) begin
                    o_cmd.pop    = 1'b1;
                    n_fin_status = ST_OK;
                    n_state      = S_FIN;
                end else begin
                    o_cmd.rd_second = 1'b1;
                    n_state         = S_RD_A;
                end
            end
            S_RD_A: begin
                // divisor zero is checked only after underflow
                if (i_sts.is_div && i_sts.b_zero) begin
                    n_fin_status = ST_DIV_ZERO;
                    n_state      = S_FIN;
                end else if (i_sts.is_div) begin
                    o_cmd.div_go = 1'b1;
                    n_state      = S_DIV;
                end else begin
                    o_cmd.alu_go = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.wb_alu = 1'b1;
                n_fin_status = ST_OK;
                n_state      = S_FIN;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.wb_div = 1'b1;
                    n_fin_status = ST_OK;
                    n_state      = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fin_status <= ST_OK;
        end else begin
            r_state      <= n_state;
            r_fin_status <= n_fin_status;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: rtl/stack_machine_executor.sv
// top level of the stack machine executor: controller plus datapath
// depends on sme_pkg, sme_ctrl and sme_datapath
//
//   channel  valid        stall        payload
//   input    i_in_valid   o_in_stall   i_in  (t_in_item)
//   output   o_out_valid  i_out_stall  o_out (t_out_item)
//
// one item at a time: each is loaded, decoded and finished; writes also pop
// an operand; add, sub, mul read two and execute; div and mod use the divider
// the operand ram has one read port, so an arithmetic item reads its operands
// in turn; a finished result waits in the output register while stalled
// reset clears the stack pointer and halted flag; ram contents are not cleared
module stack_machine_executor
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    t_cmd cmd;
    t_sts sts;

    sme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    sme_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
